// ===== design/vcbc_pkg.sv =====
// Shared types, constants and letter arithmetic for the Vigenere CBC encryptor.
package vcbc_pkg;

    localparam int MAX_KEY_LETTERS = 8;
    localparam int LETTER_W        = 5;
    localparam int PACK_LETTERS    = 8;
    localparam int PACK_W          = LETTER_W * PACK_LETTERS;
    localparam int LEN_REG_W       = 4;
    localparam int POS_W           = (MAX_KEY_LETTERS > 1) ? $clog2(MAX_KEY_LETTERS) : 1;
    localparam int LEN_W           = $clog2(MAX_KEY_LETTERS + 1);
    localparam int SUM_W           = 7;
    localparam int APB_DATA_W      = 64;
    localparam int APB_ADDR_W      = 5;

    localparam logic [LETTER_W-1:0] ALPHABET = LETTER_W'(26);

    // Register byte addresses (registers are 8 bytes apart).
    localparam logic [APB_ADDR_W-1:0] ADDR_KEY_LETTERS = APB_ADDR_W'(0);
    localparam logic [APB_ADDR_W-1:0] ADDR_KEY_LENGTH  = APB_ADDR_W'(8);
    localparam logic [APB_ADDR_W-1:0] ADDR_IV_LETTERS  = APB_ADDR_W'(16);

    typedef struct packed {
        logic [LETTER_W-1:0] plain_letter;
        logic                message_end;
    } in_item_t;

    typedef struct packed {
        logic [LETTER_W-1:0] cipher_letter;
        logic                run_last;
    } out_item_t;

    // Letter n of a packed 40-bit letter word; positions past the word read as zero.
    function automatic logic [LETTER_W-1:0] letter_at(input logic [PACK_W-1:0] packed_word,
                                                      input logic [POS_W-1:0]  n);
        logic [LETTER_W-1:0] result;
        result = '0;
        for (int i = 0; i < PACK_LETTERS; i++) begin
            if (32'(n) == i) begin
                result = packed_word[LETTER_W*i +: LETTER_W];
            end
        end
        return result;
    endfunction

    // Reduce a three-letter sum (at most 93) to 0..25.
    function automatic logic [LETTER_W-1:0] mod_alphabet(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0] r;
        if (sum >= SUM_W'(78)) begin
            r = sum - SUM_W'(78);
        end else if (sum >= SUM_W'(52)) begin
            r = sum - SUM_W'(52);
        end else if (sum >= SUM_W'(26)) begin
            r = sum - SUM_W'(26);
        end else begin
            r = sum;
        end
        return r[LETTER_W-1:0];
    endfunction

endpackage

// ===== design/vigenere_cbc_encrypt.sv =====
// Vigenere cipher in a CBC-style chain, with a shared add and reduce unit under a sequencer.
// An accepted request starts the sequencer, and no new one is taken until it is idle again.
// Results enter the output register when it is empty or being emptied; a message's last letter is
// followed by its pads; the single unit makes one letter per cycle unless the output stalls.
// Reset (aresetn low at a rising edge): sequencer idle, output empty, block position zero,
// first block set, key and IV zero, key length one. The chain store is not cleared.
module vigenere_cbc_encrypt (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  vcbc_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output vcbc_pkg::out_item_t               m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vcbc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [vcbc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [vcbc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import vcbc_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CALC = 1'b1;

    // Configuration registers.
    logic [PACK_W-1:0]    key_letters_reg;
    logic [LEN_REG_W-1:0] key_length_reg;
    logic [PACK_W-1:0]    iv_letters_reg;

    // Sequencer and block state.
    logic                 state_reg, state_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 first_reg, first_next;
    logic [LETTER_W-1:0]  plain_reg;
    logic                 last_reg;
    logic                 pad_phase_reg, pad_phase_next;
    logic [POS_W-1:0]     pad_reg, pad_next;

    // Ciphertext of the previous block, one letter per position.
    logic [LETTER_W-1:0]  chain_mem [MAX_KEY_LETTERS];

    // Output register.
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_data_reg;

    logic                 cfg_write;
    logic [LEN_W-1:0]     blk_len;
    logic                 accept;
    logic                 load_out;
    logic [LETTER_W-1:0]  operand;
    logic [LETTER_W-1:0]  chain_letter;
    logic [SUM_W-1:0]     sum;
    logic [LETTER_W-1:0]  cipher;
    logic [LEN_W:0]       pos_inc;
    logic                 block_done;
    logic                 fin;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        unique case (paddr)
            ADDR_KEY_LETTERS: prdata = APB_DATA_W'(key_letters_reg);
            ADDR_KEY_LENGTH:  prdata = APB_DATA_W'(key_length_reg);
            ADDR_IV_LETTERS:  prdata = APB_DATA_W'(iv_letters_reg);
            default:          prdata = '0;
        endcase
    end

    // Block length: a length of zero counts as one, and it saturates at the store depth.
    always_comb begin
        if (key_length_reg == '0) begin
            blk_len = LEN_W'(1);
        end else if (32'(key_length_reg) > MAX_KEY_LETTERS) begin
            blk_len = LEN_W'(MAX_KEY_LETTERS);
        end else begin
            blk_len = LEN_W'(key_length_reg);
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    // The unit fires when the output register is empty or being emptied this cycle.
    assign load_out = (state_reg == ST_CALC) && (!m_valid_reg || m_ready);

    // The shared unit: the letter (or pad) plus chain plus key, reduced mod 26.
    assign operand      = pad_phase_reg ? LETTER_W'(pad_reg) : plain_reg;
    assign chain_letter = first_reg ? letter_at(iv_letters_reg, pos_reg) : chain_mem[pos_reg];
    assign sum          = SUM_W'(operand) + SUM_W'(chain_letter)
                        + SUM_W'(letter_at(key_letters_reg, pos_reg));
    assign cipher       = mod_alphabet(sum);

    assign pos_inc    = (LEN_W + 1)'(pos_reg) + (LEN_W + 1)'(1);
    assign block_done = (pos_inc >= (LEN_W + 1)'(blk_len));
    // The final result of a message: the last letter's block is full after this one.
    assign fin        = last_reg && block_done;

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        first_next     = first_reg;
        pad_phase_next = pad_phase_reg;
        pad_next       = pad_reg;
        m_valid_next   = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        priority if (accept) begin
            state_next     = ST_CALC;
            pad_phase_next = 1'b0;
            pad_next       = '0;
            // A key length lowered mid-block starts a new chained block.
            if ((LEN_W + 1)'(pos_reg) >= (LEN_W + 1)'(blk_len)) begin
                pos_next   = '0;
                first_next = 1'b0;
            end
        end else if (load_out) begin
            m_valid_next = 1'b1;
            if (!last_reg) begin
                state_next = ST_IDLE;
                if (block_done) begin
                    pos_next   = '0;
                    first_next = 1'b0;
                end else begin
                    pos_next = pos_inc[POS_W-1:0];
                end
            end else if (fin) begin
                // Message complete: the next message chains from the IV again.
                state_next = ST_IDLE;
                pos_next   = '0;
                first_next = 1'b1;
            end else begin
                pos_next       = pos_inc[POS_W-1:0];
                pad_phase_next = 1'b1;
                if (pad_phase_reg) begin
                    pad_next = pad_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            pos_reg         <= '0;
            first_reg       <= 1'b1;
            pad_phase_reg   <= 1'b0;
            pad_reg         <= '0;
            m_valid_reg     <= 1'b0;
            key_letters_reg <= '0;
            key_length_reg  <= LEN_REG_W'(1);
            iv_letters_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            first_reg     <= first_next;
            pad_phase_reg <= pad_phase_next;
            pad_reg       <= pad_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_write) begin
                unique case (paddr)
                    ADDR_KEY_LETTERS: key_letters_reg <= pwdata[PACK_W-1:0];
                    ADDR_KEY_LENGTH:  key_length_reg  <= pwdata[LEN_REG_W-1:0];
                    ADDR_IV_LETTERS:  iv_letters_reg  <= pwdata[PACK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            plain_reg <= s_data.plain_letter;
            last_reg  <= s_data.message_end;
        end
        if (load_out) begin
            m_data_reg.cipher_letter <= cipher;
            m_data_reg.run_last      <= fin;
            chain_mem[pos_reg]       <= cipher;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_cipher_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.cipher_letter < ALPHABET))
        else $error("cipher letter out of range");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_CALC))
        else $error("accepted request did not start the sequencer");

    a_message_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && fin) |=> (first_reg && (pos_reg == '0) && (state_reg == ST_IDLE)))
        else $error("message end did not restart the chain");

    a_load_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_valid_reg)
        else $error("computed letter was not presented");
`endif

endmodule

// ===== dv/vigenere_cbc_encrypt_test.sv =====
// Self-checking testbench for the Vigenere CBC encryptor: directed and random letter streams.
`timescale 1ns / 100ps

module vigenere_cbc_encrypt_test;
    import vcbc_pkg::*;

    // Cycles without any accepted request, result or register access before the run is
    // declared hung. The longest legitimate quiet spell is the receiver hold-off below.
    localparam int WATCHDOG_LIMIT = 2000;
    // Length of the deliberate receiver hold-off, long enough to back the block up.
    localparam int HOLD_OFF_CYCLES = 80;
    // Idle chance per cycle, in percent, for both the sender and the receiver.
    localparam int IDLE_PERCENT = 27;
    // Settling time after the last result before a register write or the final verdict.
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PHASES = 10;
    localparam logic [PACK_W-1:0] ALL_ONES_LETTERS = '1;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    // Shadow copy of the configuration registers, updated as each write lands.
    logic [PACK_W-1:0] key_reg = '0;
    logic [LEN_REG_W-1:0] klen_reg = LEN_REG_W'(1);
    logic [PACK_W-1:0] iv_reg = '0;

    // Cipher state as the block should hold it: position in the current block, whether
    // the IV still feeds the chain, and the previous ciphertext block.
    int unsigned block_pos = 0;
    bit first_blk = 1'b1;
    logic [LETTER_W-1:0] chain_mem [MAX_KEY_LETTERS];

    in_item_t letters_to_send[$];
    out_item_t cipher_due[$];

    int mismatches = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit no_gaps = 1'b0;
    bit long_stall_req = 1'b0;
    bit mid_msg = 1'b0;

    vigenere_cbc_encrypt u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // The block length that a key length register value stands for: zero acts as one,
    // and anything past the maximum saturates.
    function automatic int unsigned block_length(input logic [LEN_REG_W-1:0] klen);
        if (klen == '0) begin
            return 1;
        end
        if (int'(klen) > MAX_KEY_LETTERS) begin
            return MAX_KEY_LETTERS;
        end
        return int'(klen);
    endfunction

    // Encrypt one letter at block position p and remember it as the chain for the next block.
    // Letters above Z enter the sum unchanged; only the sum is reduced.
    function automatic logic [LETTER_W-1:0] chain_cipher(input logic [LETTER_W-1:0] letter,
                                                         input int unsigned p);
        logic [LETTER_W-1:0] link;
        logic [SUM_W-1:0] total;
        link = first_blk ? iv_reg[LETTER_W*p +: LETTER_W] : chain_mem[p];
        total = SUM_W'(letter) + SUM_W'(link) + SUM_W'(key_reg[LETTER_W*p +: LETTER_W]);
        chain_mem[p] = LETTER_W'(total % SUM_W'(ALPHABET));
        return chain_mem[p];
    endfunction

    // Work out every result that one accepted request causes and queue them in order.
    // On a message end the rest of the block is filled with pad letters A, B, C and so on,
    // and the flag marking the end of the run goes on the very last one.
    function automatic void encipher_letter(input in_item_t req);
        int unsigned len;
        int unsigned p;
        int unsigned n;
        logic [LETTER_W-1:0] pad;
        logic [LETTER_W-1:0] burst [MAX_KEY_LETTERS];
        out_item_t res;
        len = block_length(klen_reg);
        // A key length lowered under the current position starts a new, chained block.
        if (block_pos >= len) begin
            block_pos = 0;
            first_blk = 1'b0;
        end
        p = block_pos;
        burst[0] = chain_cipher(req.plain_letter, p);
        n = 1;
        p++;
        if (!req.message_end) begin
            if (p >= len) begin
                block_pos = 0;
                first_blk = 1'b0;
            end else begin
                block_pos = p;
            end
        end else begin
            pad = '0;
            while (p < len) begin
                burst[n] = chain_cipher(pad, p);
                n++;
                pad++;
                p++;
            end
            block_pos = 0;
            first_blk = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            res.cipher_letter = burst[i];
            res.run_last = req.message_end && (i == n - 1);
            cipher_due.push_back(res);
        end
    endfunction

    // Sender: offers the queued letters in order, idling at random between requests.
    // A request stays up with its payload unchanged until the block takes it.
    always @(posedge aclk) begin : sender
        in_item_t next_item;
        bit next_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            next_item = s_data;
            if (s_valid && s_ready) begin
                encipher_letter(s_data);
                next_valid = 1'b0;
            end
            if (!next_valid && letters_to_send.size() > 0 &&
                (no_gaps || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                next_item = letters_to_send.pop_front();
                next_valid = 1'b1;
            end
            s_valid <= next_valid;
            s_data <= next_item;
        end
    end

    // Receiver: checks each accepted result against the oldest outstanding prediction and
    // throttles m_ready, including one long hold-off counted here when asked for.
    always @(posedge aclk) begin : receiver
        out_item_t want;
        bit next_ready;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (cipher_due.size() == 0) begin
                    $error("unexpected result: cipher_letter %0d run_last %0b",
                           m_data.cipher_letter, m_data.run_last);
                    mismatches++;
                end else begin
                    want = cipher_due.pop_front();
                    if (m_data.cipher_letter !== want.cipher_letter) begin
                        $error("cipher_letter: expected %0d, actual %0d",
                               want.cipher_letter, m_data.cipher_letter);
                        mismatches++;
                    end
                    if (m_data.run_last !== want.run_last) begin
                        $error("run_last: expected %0b, actual %0b",
                               want.run_last, m_data.run_last);
                        mismatches++;
                    end
                end
            end
            next_ready = 1'b1;
            if (long_stall_req && stall_left == 0) begin
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else if (!no_gaps && $urandom_range(0, 99) < IDLE_PERCENT) begin
                next_ready = 1'b0;
            end
            m_ready <= next_ready;
        end
    end

    // Watchdog: any request, result or register access counts as progress.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Register write over the APB-style port: setup cycle, then access until pready.
    // The shadow copy follows once the write has landed.
    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            ADDR_KEY_LETTERS: key_reg = value[PACK_W-1:0];
            ADDR_KEY_LENGTH:  klen_reg = value[LEN_REG_W-1:0];
            ADDR_IV_LETTERS:  iv_reg = value[PACK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic add_letter(input logic [LETTER_W-1:0] letter, input bit ends);
        in_item_t item;
        item.plain_letter = letter;
        item.message_end = ends;
        letters_to_send.push_back(item);
    endtask

    // A message of random letters, now and then one of the out-of-alphabet codes.
    task automatic add_message(input int n_letters, input bit ends);
        for (int i = 0; i < n_letters; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                add_letter(LETTER_W'($urandom_range(26, 31)), ends && (i == n_letters - 1));
            end else begin
                add_letter(LETTER_W'($urandom_range(0, 25)), ends && (i == n_letters - 1));
            end
        end
    endtask

    // Packed key or IV word: mostly real letters, sometimes the codes above Z.
    function automatic logic [PACK_W-1:0] random_letters();
        logic [PACK_W-1:0] word;
        for (int i = 0; i < PACK_LETTERS; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                word[LETTER_W*i +: LETTER_W] = LETTER_W'($urandom_range(26, 31));
            end else begin
                word[LETTER_W*i +: LETTER_W] = LETTER_W'($urandom_range(0, 25));
            end
        end
        return word;
    endfunction

    // The stimulus holds back until every queued request has gone in and every predicted
    // result has come out; only then is the block idle enough for register writes.
    // The queues and the request line are looked at on the falling edge, once the
    // updates of the rising edge have all settled.
    task automatic drain();
        while (letters_to_send.size() != 0 || s_valid || cipher_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int total;
        int n;
        bit ends;
        int unsigned cap;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset configuration: key length one, zero key and IV, so letters pass straight
        // through apart from the reduction of the codes above Z.
        add_letter(LETTER_W'(0), 1'b1);
        add_letter(LETTER_W'(31), 1'b1);
        drain();

        // Every key and IV letter at its largest code and a full-length block. A lone last
        // letter pads out the other seven positions, the longest burst there is.
        write_register(ADDR_KEY_LETTERS, APB_DATA_W'(ALL_ONES_LETTERS));
        write_register(ADDR_IV_LETTERS, APB_DATA_W'(ALL_ONES_LETTERS));
        write_register(ADDR_KEY_LENGTH, APB_DATA_W'(8));
        add_letter(LETTER_W'(31), 1'b1);
        add_letter(LETTER_W'(0), 1'b0);
        add_letter(LETTER_W'(25), 1'b1);
        drain();

        // Short blocks: one message that fills its block exactly, then one that chains
        // into a second block and needs two pad letters.
        write_register(ADDR_KEY_LETTERS, APB_DATA_W'(random_letters()));
        write_register(ADDR_IV_LETTERS, APB_DATA_W'(random_letters()));
        write_register(ADDR_KEY_LENGTH, APB_DATA_W'(3));
        add_message(3, 1'b1);
        add_message(4, 1'b1);
        drain();

        // A key length of zero behaves as one; lengths past the maximum saturate.
        write_register(ADDR_KEY_LENGTH, APB_DATA_W'(0));
        add_message(2, 1'b1);
        drain();
        write_register(ADDR_KEY_LENGTH, APB_DATA_W'(9));
        add_message(1, 1'b1);
        drain();
        write_register(ADDR_KEY_LENGTH, APB_DATA_W'(15));
        add_message(1, 1'b1);
        drain();

        // Mid-message changes. First the key length drops below the current position, so
        // the next letter opens a new chained block, and the key changes along with it.
        write_register(ADDR_KEY_LENGTH, APB_DATA_W'(6));
        add_message(4, 1'b0);
        drain();
        write_register(ADDR_KEY_LENGTH, APB_DATA_W'(2));
        write_register(ADDR_KEY_LETTERS, APB_DATA_W'(random_letters()));
        add_message(2, 1'b1);
        drain();
        // Then a drop that stays above the position, so the current block just ends sooner.
        write_register(ADDR_KEY_LENGTH, APB_DATA_W'(5));
        add_message(2, 1'b0);
        drain();
        write_register(ADDR_KEY_LENGTH, APB_DATA_W'(4));
        write_register(ADDR_IV_LETTERS, APB_DATA_W'(random_letters()));
        add_message(1, 1'b1);
        drain();

        // Random phases with a fresh configuration each. A phase may stop in the middle of
        // a message; the key length may then only shrink, since a longer block would chain
        // from ciphertext letters that were never produced.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (mid_msg) begin
                cap = block_length(klen_reg);
                write_register(ADDR_KEY_LENGTH, APB_DATA_W'($urandom_range(1, cap)));
            end else begin
                write_register(ADDR_KEY_LENGTH, APB_DATA_W'($urandom_range(0, 15)));
            end
            write_register(ADDR_KEY_LETTERS, APB_DATA_W'(random_letters()));
            write_register(ADDR_IV_LETTERS, APB_DATA_W'(random_letters()));

            @(posedge aclk);
            no_gaps <= (phase == 3);

            total = 0;
            while (total < ((phase == 6) ? 40 : 16)) begin
                n = $urandom_range(1, 10);
                total += n;
                ends = (total < 16) || ($urandom_range(0, 3) != 0);
                add_message(n, ends);
                mid_msg = !ends;
            end

            // One phase backs the block up: the receiver stops for a long stretch while the
            // sender keeps offering requests, until the block refuses further input.
            if (phase == 6) begin
                @(posedge aclk);
                long_stall_req <= 1'b1;
                @(posedge aclk);
                long_stall_req <= 1'b0;
            end
            drain();
        end

        if (mid_msg) begin
            add_message(1, 1'b1);
        end
        no_gaps <= 1'b0;
        drain();

        if (mismatches == 0 && cipher_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
